// ===== design/bpfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfm_pkg: shared types for the buffer pool frame manager
// Request/result payload structs and status codes.
// ----------------------------------------------------------------------------
package bpfm_pkg;

  localparam logic CMD_FIX   = 1'b0;
  localparam logic CMD_UNFIX = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BAD_UNF = 2'd2;
  localparam logic [1:0] ST_PIN_SAT = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [15:0] file_no;
    logic [31:0] page_no;
    logic        create_new;
    logic [5:0]  unfix_frame;
    logic        mark_dirty;
  } req_t;

  typedef struct packed {
    logic [5:0]  frame_id;
    logic        hit;
    logic        need_read;
    logic        need_writeback;
    logic [15:0] victim_file_no;
    logic [31:0] victim_page_no;
    logic [1:0]  status;
  } rsp_t;

endpackage

// ===== design/bpfm_lookup.sv =====
// ----------------------------------------------------------------------------
// bpfm_lookup: associative tag match
// Finds the lowest valid frame whose tag equals the requested page id.
// ----------------------------------------------------------------------------
module bpfm_lookup #(
  parameter int FRAMES = 64,
  parameter int FW     = 6
) (
  input  logic [FRAMES-1:0]       valid,
  input  logic [FRAMES-1:0][15:0] tfile,
  input  logic [FRAMES-1:0][31:0] tpage,
  input  logic [15:0]             file_no,
  input  logic [31:0]             page_no,
  output logic                    found,
  output logic [FW-1:0]           idx
);
  logic [FRAMES-1:0] m;
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      m[i] = valid[i] && tfile[i] == file_no && tpage[i] == page_no;
    end
    found = |m;
    idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = FW'(i);
      end
    end
  end
endmodule

// ===== design/buffer_pool_frame_manager_lru.sv =====
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager_lru: page buffer pool frame table
// Pin counts, free stack and LRU replacement over a fully associative table.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per transfer (fix by page id, or unfix by frame).
//   out_* : one result per request, in order.
// Each request is processed in one pass of combinational logic from the
// frame table state and the result is registered: out_valid rises in the
// cycle after the input transfer, and one request is accepted every cycle
// unless the output stalls (tag compare and list decode are combinational).
// The output register holds a result while out_ready is low; a new request
// is accepted in that cycle only if the held result is taken.
// Reset (synchronous, rst_n low) empties the LRU list, marks all frames
// free, unpinned, clean and invalid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager_lru #(
  parameter int FRAMES   = 64,
  parameter int PIN_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bpfm_pkg::req_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bpfm_pkg::rsp_t   out_data
);
  localparam int FW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

  logic [FRAMES-1:0][15:0]       tfile_r;
  logic [FRAMES-1:0][31:0]       tpage_r;
  logic [FRAMES-1:0]             valid_r, dirty_r;
  logic [FRAMES-1:0][PIN_BITS-1:0] pin_r;
  logic [FRAMES-1:0][FW-1:0]     prev_r, next_r;
  logic [FW-1:0]                 head_r, tail_r;
  logic                          empty_r;
  logic [CW-1:0]                 free_r;
  logic                          ov_r;
  bpfm_pkg::rsp_t                out_r;

  logic found;
  logic [FW-1:0] hidx;
  bpfm_lookup #(.FRAMES(FRAMES), .FW(FW)) u_lookup (
    .valid(valid_r), .tfile(tfile_r), .tpage(tpage_r),
    .file_no(in_data.file_no), .page_no(in_data.page_no),
    .found(found), .idx(hidx)
  );

  logic go;
  assign in_ready  = !ov_r || out_ready;
  assign go        = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // unlink/append requests decoded here, applied in the clocked block
  logic          do_unlink, do_append, do_alloc, do_pinup, do_pindn;
  logic [FW-1:0] uf_idx, f_sel, ufr;
  logic          uf_ok;
  bpfm_pkg::rsp_t rsp;

  always_comb begin
    rsp = '0;
    do_unlink = 1'b0; do_append = 1'b0; do_alloc = 1'b0;
    do_pinup = 1'b0; do_pindn = 1'b0;
    f_sel = '0;
    ufr = in_data.unfix_frame[FW-1:0];
    uf_ok = (FRAMES >= 64 || {26'd0, in_data.unfix_frame} < FRAMES)
            && valid_r[ufr] && pin_r[ufr] != '0;
    uf_idx = ufr;
    if (in_data.cmd == bpfm_pkg::CMD_FIX) begin
      if (found) begin
        f_sel = hidx;
        rsp.hit = 1'b1;
        if (pin_r[hidx] == PIN_MAX) begin
          rsp.status = bpfm_pkg::ST_PIN_SAT;
        end else begin
          do_pinup = 1'b1;
          do_unlink = pin_r[hidx] == '0;
        end
      end else if (free_r != '0) begin
        f_sel = FW'(free_r - CW'(1));
        do_alloc = 1'b1;
      end else if (!empty_r) begin
        f_sel = head_r;
        do_alloc = 1'b1;
        do_unlink = 1'b1;
        if (dirty_r[head_r]) begin
          rsp.need_writeback = 1'b1;
          rsp.victim_file_no = tfile_r[head_r];
          rsp.victim_page_no = tpage_r[head_r];
        end
      end else begin
        rsp.status = bpfm_pkg::ST_NO_FREE;
      end
      if (do_alloc) begin
        rsp.need_read = !in_data.create_new;
      end
      rsp.frame_id = 6'(f_sel);
    end else begin
      rsp.frame_id = in_data.unfix_frame;
      if (!uf_ok) begin
        rsp.status = bpfm_pkg::ST_BAD_UNF;
      end else begin
        do_pindn = 1'b1;
        do_append = pin_r[ufr] == PIN_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      valid_r <= '0;
      dirty_r <= '0;
      pin_r   <= '0;
      empty_r <= 1'b1;
      head_r  <= '0;
      tail_r  <= '0;
      free_r  <= CW'(FRAMES);
    end else begin
      if (go) begin
        ov_r  <= 1'b1;
        out_r <= rsp;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      if (go) begin
        if (do_unlink) begin
          if (head_r == f_sel && tail_r == f_sel) begin
            empty_r <= 1'b1;
          end else if (head_r == f_sel) begin
            head_r <= next_r[f_sel];
          end else if (tail_r == f_sel) begin
            tail_r <= prev_r[f_sel];
          end else begin
            next_r[prev_r[f_sel]] <= next_r[f_sel];
            prev_r[next_r[f_sel]] <= prev_r[f_sel];
          end
        end
        if (do_pinup) begin
          pin_r[f_sel] <= pin_r[f_sel] + PIN_BITS'(1);
        end
        if (do_alloc) begin
          if (free_r != '0) begin
            free_r <= free_r - CW'(1);
          end
          tfile_r[f_sel] <= in_data.file_no;
          tpage_r[f_sel] <= in_data.page_no;
          valid_r[f_sel] <= 1'b1;
          dirty_r[f_sel] <= 1'b0;
          pin_r[f_sel]   <= PIN_BITS'(1);
        end
        if (do_pindn) begin
          pin_r[uf_idx] <= pin_r[uf_idx] - PIN_BITS'(1);
          if (in_data.mark_dirty) begin
            dirty_r[uf_idx] <= 1'b1;
          end
        end
        if (do_append) begin
          if (empty_r) begin
            head_r  <= uf_idx;
            tail_r  <= uf_idx;
            empty_r <= 1'b0;
          end else begin
            next_r[tail_r] <= uf_idx;
            prev_r[uf_idx] <= tail_r;
            tail_r <= uf_idx;
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CW'(FRAMES))
    else $error("free count out of range");
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    go && rsp.need_writeback |-> free_r == '0 && !empty_r)
    else $error("write-back without eviction");
  a_nofree: assert property (@(posedge clk) disable iff (!rst_n)
    go && rsp.status == bpfm_pkg::ST_NO_FREE |-> empty_r && free_r == '0)
    else $error("no-frame status with frames available");
`endif
endmodule

// ===== sim/buffer_pool_frame_manager_lru_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager_lru_checker: frame table predictor and scoreboard
// Watches request and result transfers, tracks the frame table (tags, pins,
// dirty bits, free stack, LRU list) and compares each result as a whole.
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager_lru_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  bpfm_pkg::req_t   in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  bpfm_pkg::rsp_t   out_data,
  output int               fail_count,
  output int               pending
);

  localparam int NFRAMES = 64;
  localparam int PIN_MAX = 255;
  localparam int EXP_DEPTH = 8;

  logic [15:0] tag_file [NFRAMES];
  logic [31:0] tag_page [NFRAMES];
  bit          resident [NFRAMES];
  int          pins     [NFRAMES];
  bit          dirty    [NFRAMES];
  int          lru_prev [NFRAMES];
  int          lru_next [NFRAMES];
  int          lru_head, lru_tail, free_top;
  bit          lru_empty;
  // expected results in flight, kept as a small ring
  bpfm_pkg::rsp_t exp_ring [EXP_DEPTH];
  int          exp_wr, exp_rd, exp_count;

  assign pending = exp_count;

  function automatic void lru_remove(int f);
    if (lru_head == f && lru_tail == f) lru_empty = 1;
    else if (lru_head == f) lru_head = lru_next[f];
    else if (lru_tail == f) lru_tail = lru_prev[f];
    else begin
      lru_next[lru_prev[f]] = lru_next[f];
      lru_prev[lru_next[f]] = lru_prev[f];
    end
  endfunction

  function automatic void lru_push_tail(int f);
    if (lru_empty) begin
      lru_head = f;
      lru_tail = f;
      lru_empty = 0;
    end else begin
      lru_next[lru_tail] = f;
      lru_prev[f] = lru_tail;
      lru_tail = f;
    end
  endfunction

  function automatic bpfm_pkg::rsp_t apply_request(bpfm_pkg::req_t rq);
    bpfm_pkg::rsp_t r;
    int   f;
    bit   found;
    r = '0;
    found = 0;
    f = 0;
    if (rq.cmd == bpfm_pkg::CMD_FIX) begin
      for (int i = 0; i < NFRAMES; i++)
        if (!found && resident[i] && tag_file[i] == rq.file_no
            && tag_page[i] == rq.page_no) begin
          found = 1;
          f = i;
        end
      if (found) begin
        r.frame_id = 6'(f);
        r.hit = 1;
        if (pins[f] >= PIN_MAX) r.status = bpfm_pkg::ST_PIN_SAT;
        else begin
          if (pins[f] == 0) lru_remove(f);
          pins[f]++;
        end
      end else if (free_top == 0 && lru_empty) begin
        r.status = bpfm_pkg::ST_NO_FREE;
      end else begin
        if (free_top > 0) begin
          free_top--;
          f = free_top;
        end else begin
          f = lru_head;
          lru_remove(f);
          if (dirty[f]) begin
            r.need_writeback = 1;
            r.victim_file_no = tag_file[f];
            r.victim_page_no = tag_page[f];
          end
        end
        tag_file[f] = rq.file_no;
        tag_page[f] = rq.page_no;
        resident[f] = 1;
        dirty[f] = 0;
        pins[f] = 1;
        r.frame_id = 6'(f);
        r.need_read = !rq.create_new;
      end
    end else begin
      f = rq.unfix_frame;
      r.frame_id = rq.unfix_frame;
      if (!resident[f] || pins[f] == 0) r.status = bpfm_pkg::ST_BAD_UNF;
      else begin
        if (rq.mark_dirty) dirty[f] = 1;
        pins[f]--;
        if (pins[f] == 0) lru_push_tail(f);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NFRAMES; i++) begin
        resident[i] = 0;
        pins[i] = 0;
        dirty[i] = 0;
      end
      lru_empty = 1;
      lru_head = 0;
      lru_tail = 0;
      free_top = NFRAMES;
      exp_wr = 0;
      exp_rd = 0;
      exp_count = 0;
      fail_count = 0;
    end else begin
      // result side first: a request taken on the same edge has no result out yet
      if (out_valid && out_ready) begin
        if (exp_count == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer %p", out_data);
        end else begin
          bpfm_pkg::rsp_t e;
          e = exp_ring[exp_rd];
          exp_rd = (exp_rd + 1) % EXP_DEPTH;
          exp_count--;
          if (e !== out_data) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (exp_count == EXP_DEPTH) begin
          fail_count++;
          if (fail_count <= 10) $display("too many requests without a result");
        end else begin
          exp_ring[exp_wr] = apply_request(in_data);
          exp_wr = (exp_wr + 1) % EXP_DEPTH;
          exp_count++;
        end
      end
    end
  end

endmodule

// ===== sim/buffer_pool_frame_manager_lru_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager_lru_tb: regression for the frame table
// Directed corner requests, then random fix/unfix streams over a small page
// pool under several idle and stall mixes; checking lives in the checker.
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager_lru_tb;

  localparam int HELD_MAX = 40;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  bpfm_pkg::req_t in_data;
  bpfm_pkg::rsp_t out_data;
  int   fail_count, pending, idle_pct, stall_pct, idle_cycles, sent;
  int   held [HELD_MAX];
  int   held_n;

  buffer_pool_frame_manager_lru dut (.*);
  buffer_pool_frame_manager_lru_checker chk (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("buffer_pool_frame_manager_lru regression: fail");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // in_valid stays up between back-to-back transfers; send drops it for an idle gap
  task automatic send(bpfm_pkg::req_t rq);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    in_data <= rq;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  function automatic bpfm_pkg::req_t fix_req(logic [15:0] fno, logic [31:0] pno, logic cn);
    bpfm_pkg::req_t r;
    r = '0;
    r.cmd = bpfm_pkg::CMD_FIX;
    r.file_no = fno;
    r.page_no = pno;
    r.create_new = cn;
    r.unfix_frame = 6'($urandom);
    r.mark_dirty = 1'($urandom);
    return r;
  endfunction

  function automatic bpfm_pkg::req_t unfix_req(logic [5:0] f, logic md);
    bpfm_pkg::req_t r;
    r = '0;
    r.cmd = bpfm_pkg::CMD_UNFIX;
    r.unfix_frame = f;
    r.mark_dirty = md;
    r.file_no = 16'($urandom);
    r.page_no = $urandom;
    r.create_new = 1'($urandom);
    return r;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    held_n = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: bad unfix of an empty frame, extremes of the id fields
    send(unfix_req(6'd63, 1'b1));
    send(fix_req(16'hFFFF, 32'hFFFF_FFFF, 1'b0));
    send(fix_req(16'h0000, 32'h0000_0000, 1'b1));
    send(fix_req(16'hFFFF, 32'hFFFF_FFFF, 1'b1));        // hit
    send(unfix_req(6'd63, 1'b1));
    send(unfix_req(6'd63, 1'b1));
    send(unfix_req(6'd63, 1'b0));                        // pin already zero
    send(unfix_req(6'd62, 1'b0));
    // pin saturation on frame 62, which then stays pinned
    for (int i = 0; i < 256; i++) send(fix_req(16'h0000, 32'h0, 1'b0));
    // fill every free frame, then evict dirty frame 63 and miss with nothing free
    for (int i = 0; i < 62; i++) send(fix_req(16'h1234, 32'(i), i[0]));
    send(fix_req(16'hAAAA, 32'h5555_5555, 1'b0));
    send(fix_req(16'h5555, 32'hAAAA_AAAA, 1'b0));        // no frame free
    for (int i = 0; i < 64; i++) send(unfix_req(6'(i), 1'b1));
    send(fix_req(16'h0001, 32'h1, 1'b0));                // evict dirty LRU head
    // random phases over a small page pool so hits and evictions are common
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        3: begin idle_pct = 21; stall_pct = 21; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < 50; n++) begin
        int k;
        k = $urandom_range(99);
        if (k < 50) begin
          send(fix_req(16'($urandom_range(3)), 32'($urandom_range(40)), 1'($urandom)));
        end else if (k < 85 && held_n > 0) begin
          int j;
          j = $urandom_range(held_n - 1);
          send(unfix_req(6'(held[j]), 1'($urandom)));
          held[j] = held[held_n - 1];
          held_n--;
        end else if (k < 90) begin
          send(fix_req(16'($urandom), $urandom, 1'($urandom)));
        end else begin
          send(unfix_req(6'($urandom), 1'($urandom)));
        end
        // random frame numbers to unfix later
        if (held_n < HELD_MAX) begin
          held[held_n] = $urandom_range(63);
          held_n++;
        end
      end
    end
    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("covered %0d requests: directed corners, pin saturation, full pool,", sent);
    $display("dirty eviction, and random fix/unfix under idle and stall mixes");
    if (fail_count == 0) $display("buffer_pool_frame_manager_lru regression: pass");
    else $display("buffer_pool_frame_manager_lru regression: fail");
    $finish;
  end

endmodule
